[hw/rtl/met_pkg.sv]
package met_pkg;

    // Fixed field widths
    localparam int COORD_BITS  = 48;
    localparam int FRAC_BITS   = 28;
    localparam int DIM_BITS    = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SIZE_BITS   = DIM_BITS + 1;
    localparam int STEP_BITS   = COORD_BITS - 1;
    localparam int OFFSET_BITS = DIM_BITS + 2;
    localparam int INDEX_BITS  = 2 * DIM_BITS;

    // Multiplier splits each magnitude into two halves
    localparam int HALF_BITS = (COORD_BITS + 1) / 2;

    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COORD_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_RE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_IM      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAILOUT        = 3'd6;

    // Post-multiply shift selection
    localparam logic [1:0] SHIFT_MAP    = 2'd0;
    localparam logic [1:0] SHIFT_SQUARE = 2'd1;
    localparam logic [1:0] SHIFT_DOUBLE = 2'd2;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [DIM_BITS-1:0] column;
        logic [DIM_BITS-1:0] row;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        iteration_count;
        logic                         interior;
        logic signed [COORD_BITS-1:0] final_re;
        logic signed [COORD_BITS-1:0] final_im;
        logic [INDEX_BITS-1:0]        pixel_index;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_re;
        logic signed [COORD_BITS-1:0] center_im;
        logic [STEP_BITS-1:0]         pixel_step;
        logic [SIZE_BITS-1:0]         image_width;
        logic [SIZE_BITS-1:0]         image_height;
        logic [COUNT_BITS-1:0]        max_iterations;
        logic [STEP_BITS-1:0]         bailout_squared;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_re:       '0,
        center_im:       '0,
        pixel_step:      47'd786432,
        image_width:     13'd1024,
        image_height:    13'd768,
        max_iterations:  16'd200,
        bailout_squared: 47'd17592186044416
    };

    // Queued work: no-iteration flag, pixel offsets (2*pixel - size) and precomputed index
    typedef struct packed {
        logic                          no_iter;
        logic signed [OFFSET_BITS-1:0] d_re;
        logic signed [OFFSET_BITS-1:0] d_im;
        logic [INDEX_BITS-1:0]         pixel_index;
    } job_t;

    typedef struct packed {
        logic       start;
        logic [1:0] shift_sel;
    } mul_req_t;

    typedef struct packed {
        logic done;
    } mul_rsp_t;

    function automatic logic signed [COORD_BITS-1:0] sat_sum(
        input logic signed [COORD_BITS:0] s
    );
        logic signed [COORD_BITS-1:0] r;
        if (s[COORD_BITS] != s[COORD_BITS-1])
        begin
            r = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r = s[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_add(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        return sat_sum(s);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_sub(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return sat_sum(s);
    endfunction

endpackage

[hw/rtl/mandelbrot_escape_time_core.sv]
// Mandelbrot escape-time engine, one pixel per item.
// Input channel (in_valid/in_ready, in_item): pixel column and row. The front
// maps the pixel to its offsets and index and drops it into a short queue, so
// new items are taken while an earlier pixel is still iterating.
// Output channel (out_valid/out_ready, out_item): iteration count, interior
// flag, final z and linear pixel index, in input order, from an output
// register. A stalled receiver holds the finished item there; the engine then
// waits in its done state and the queue fills until in_ready drops.
// Config port (cfg_write, cfg_index, cfg_data): one register per write, taken
// at the clock edge; write only while no pixel is in flight.
// Arithmetic: one shared multiply unit builds each 48x48 product from four
// 24x24 partial products, then rounds and saturates. Mapping takes 2 products,
// each iteration 3, and the test in which the pixel escapes 2 more; with zero
// limit or zero bailout no product is made. The engine works on one pixel at
// a time and takes the next from the queue once the last result is in the
// output register.
// Reset: async active low; clears queue, engine and output valid, and loads
// the default view (center 0, step 786432, 1024x768, limit 200, bailout 256^2).
module mandelbrot_escape_time_core #(
    parameter int QUEUE_DEPTH = met_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [met_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [met_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  met_pkg::in_item_t                    in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output met_pkg::out_item_t                   out_item
);

    localparam int JOB_BITS = $bits(met_pkg::job_t);

    met_pkg::cfg_t  cfg_reg, cfg_next;
    met_pkg::job_t  front_job, back_job;
    logic           push, full, pop, not_empty;
    logic [JOB_BITS-1:0] push_vec, pop_vec;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                met_pkg::REG_CENTER_RE:
                    cfg_next.center_re = cfg_data[met_pkg::COORD_BITS-1:0];
                met_pkg::REG_CENTER_IM:
                    cfg_next.center_im = cfg_data[met_pkg::COORD_BITS-1:0];
                met_pkg::REG_PIXEL_STEP:
                    cfg_next.pixel_step = cfg_data[met_pkg::STEP_BITS-1:0];
                met_pkg::REG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[met_pkg::SIZE_BITS-1:0];
                met_pkg::REG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_data[met_pkg::SIZE_BITS-1:0];
                met_pkg::REG_MAX_ITERATIONS:
                    cfg_next.max_iterations = cfg_data[met_pkg::COUNT_BITS-1:0];
                met_pkg::REG_BAILOUT:
                    cfg_next.bailout_squared = cfg_data[met_pkg::STEP_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= met_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    met_front u_front (
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .full      (full),
        .push      (push),
        .push_data (front_job)
    );

    assign push_vec = front_job;
    assign back_job = met_pkg::job_t'(pop_vec);

    met_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_vec),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_vec)
    );

    met_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (not_empty),
        .job       (back_job),
        .job_pop   (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

[hw/rtl/met_fifo.sv]
module met_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    // DEPTH of 2 or more
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/met_front.sv]
module met_front (
    input  met_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  met_pkg::in_item_t in_item,
    input  logic              full,
    output logic              push,
    output met_pkg::job_t     push_data
);

    localparam int OB = met_pkg::OFFSET_BITS;
    localparam int IB = met_pkg::INDEX_BITS;

    logic [OB-1:0] col2, row2, wide_w, wide_h;
    logic [IB:0]   index_prod;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        col2   = {1'b0, in_item.column, 1'b0};
        row2   = {1'b0, in_item.row, 1'b0};
        wide_w = {1'b0, cfg.image_width};
        wide_h = {1'b0, cfg.image_height};
        index_prod = (IB + 1)'(in_item.row) * (IB + 1)'(cfg.image_width);

        push_data.d_re        = $signed(col2 - wide_w);
        push_data.d_im        = $signed(row2 - wide_h);
        push_data.pixel_index = index_prod[IB-1:0] + IB'(in_item.column);
        // zero limit or zero bailout: no update is ever made
        push_data.no_iter     = (cfg.max_iterations == '0) || (cfg.bailout_squared == '0);
    end

endmodule

[hw/rtl/met_mul.sv]
module met_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  met_pkg::mul_req_t                     req,
    input  logic signed [met_pkg::COORD_BITS-1:0] a,
    input  logic signed [met_pkg::COORD_BITS-1:0] b,
    output met_pkg::mul_rsp_t                     rsp,
    output logic signed [met_pkg::COORD_BITS-1:0] result
);

    localparam int CB = met_pkg::COORD_BITS;
    localparam int FB = met_pkg::FRAC_BITS;
    localparam int H  = met_pkg::HALF_BITS;
    localparam int PW = 2 * H;
    localparam int AW = 4 * H;

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_PART  = 2'd1;
    localparam logic [1:0] M_ROUND = 2'd2;
    localparam logic [1:0] M_SAT   = 2'd3;

    localparam logic [AW-1:0] BIAS_MAP    = AW'(1);
    localparam logic [AW-1:0] BIAS_SQUARE = (AW'(1) << FB) - AW'(1);
    localparam logic [AW-1:0] BIAS_DOUBLE = (AW'(1) << (FB - 1)) - AW'(1);

    logic [1:0]            state_reg, state_next;
    logic [1:0]            part_reg, part_next;
    logic [PW-1:0]         ua_reg, ua_next, ub_reg, ub_next;
    logic                  neg_reg, neg_next;
    logic [1:0]            sel_reg, sel_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic [AW-1:0]         q_reg, q_next;
    logic signed [CB-1:0]  result_reg, result_next;
    logic                  done_reg, done_next;

    logic [CB-1:0] raw_a, raw_b, mag_a, mag_b, q_neg;
    logic [H-1:0]  ha, hb;
    logic [PW-1:0] pp;
    logic [AW-1:0] pp_shift, bias, biased;

    assign rsp.done = done_reg;
    assign result   = result_reg;

    always_comb
    begin
        raw_a = a;
        raw_b = b;
        mag_a = a[CB-1] ? (~raw_a + 1'b1) : raw_a;
        mag_b = b[CB-1] ? (~raw_b + 1'b1) : raw_b;

        ha = part_reg[1] ? ua_reg[PW-1:H] : ua_reg[H-1:0];
        hb = part_reg[0] ? ub_reg[PW-1:H] : ub_reg[H-1:0];
        pp = PW'(ha) * PW'(hb);
        case (part_reg)
            2'd0:    pp_shift = {{(2*H){1'b0}}, pp};
            2'd3:    pp_shift = {pp, {(2*H){1'b0}}};
            default: pp_shift = {{H{1'b0}}, pp, {H{1'b0}}};
        endcase

        // floor of a negative quotient: negate the ceiling of the magnitude
        case (sel_reg)
            met_pkg::SHIFT_MAP:    bias = BIAS_MAP;
            met_pkg::SHIFT_SQUARE: bias = BIAS_SQUARE;
            met_pkg::SHIFT_DOUBLE: bias = BIAS_DOUBLE;
            default:               bias = '0;
        endcase
        biased = acc_reg + (neg_reg ? bias : '0);

        q_neg = ~q_reg[CB-1:0] + 1'b1;

        state_next  = state_reg;
        part_next   = part_reg;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        neg_next    = neg_reg;
        sel_next    = sel_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    ua_next    = PW'(mag_a);
                    ub_next    = PW'(mag_b);
                    neg_next   = a[CB-1] ^ b[CB-1];
                    sel_next   = req.shift_sel;
                    acc_next   = '0;
                    part_next  = '0;
                    state_next = M_PART;
                end
            end
            M_PART:
            begin
                acc_next  = acc_reg + pp_shift;
                part_next = part_reg + 1'b1;
                if (part_reg == 2'd3)
                begin
                    state_next = M_ROUND;
                end
            end
            M_ROUND:
            begin
                case (sel_reg)
                    met_pkg::SHIFT_MAP:    q_next = biased >> 1;
                    met_pkg::SHIFT_DOUBLE: q_next = biased >> (FB - 1);
                    default:               q_next = biased >> FB;
                endcase
                state_next = M_SAT;
            end
            M_SAT:
            begin
                if (!neg_reg)
                begin
                    result_next = (|q_reg[AW-1:CB-1]) ? met_pkg::COORD_MAX
                                                      : $signed(q_reg[CB-1:0]);
                end
                else if ((|q_reg[AW-1:CB]) || (q_reg[CB-1] && (|q_reg[CB-2:0])))
                begin
                    result_next = met_pkg::COORD_MIN;
                end
                else
                begin
                    result_next = $signed(q_neg);
                end
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg   <= part_next;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        neg_reg    <= neg_next;
        sel_reg    <= sel_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        result_reg <= result_next;
    end

endmodule

[hw/rtl/met_back.sv]
module met_back (
    input  logic               clk,
    input  logic               rst_n,
    input  met_pkg::cfg_t      cfg,
    input  logic               job_valid,
    input  met_pkg::job_t      job,
    output logic               job_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output met_pkg::out_item_t out_item
);

    localparam int CB = met_pkg::COORD_BITS;
    localparam int OB = met_pkg::OFFSET_BITS;
    localparam int NB = met_pkg::COUNT_BITS;
    localparam int IB = met_pkg::INDEX_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAP_RE = 3'd1;
    localparam logic [2:0] S_MAP_IM = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SQ_RE  = 3'd4;
    localparam logic [2:0] S_SQ_IM  = 3'd5;
    localparam logic [2:0] S_CROSS  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    met_pkg::out_item_t   out_item_reg, out_item_next;
    logic [IB-1:0]        index_reg, index_next;
    logic signed [OB-1:0] d_im_reg, d_im_next;
    logic signed [CB-1:0] cre_reg, cre_next, cim_reg, cim_next;
    logic signed [CB-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [CB-1:0] r2_reg, r2_next;
    logic [NB-1:0]        it_reg, it_next;

    met_pkg::mul_req_t    mul_req;
    met_pkg::mul_rsp_t    mul_rsp;
    logic signed [CB-1:0] mul_a, mul_b, mul_result;

    logic signed [CB-1:0] step_s, esc_sum;
    logic                 out_free;

    met_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .a      (mul_a),
        .b      (mul_b),
        .rsp    (mul_rsp),
        .result (mul_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        step_s   = $signed({1'b0, cfg.pixel_step});
        esc_sum  = met_pkg::sat_add(r2_reg, mul_result);
        out_free = !out_valid_reg || out_ready;

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        index_next     = index_reg;
        d_im_next      = d_im_reg;
        cre_next       = cre_reg;
        cim_next       = cim_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        r2_next        = r2_reg;
        it_next        = it_reg;
        job_pop        = 1'b0;

        mul_req.start     = 1'b0;
        mul_req.shift_sel = met_pkg::SHIFT_SQUARE;
        mul_a             = zr_reg;
        mul_b             = zr_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    index_next = job.pixel_index;
                    d_im_next  = job.d_im;
                    zr_next    = '0;
                    zi_next    = '0;
                    it_next    = '0;
                    if (job.no_iter)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mul_req.start     = 1'b1;
                        mul_req.shift_sel = met_pkg::SHIFT_MAP;
                        mul_a             = {{(CB-OB){job.d_re[OB-1]}}, job.d_re};
                        mul_b             = step_s;
                        state_next        = S_MAP_RE;
                    end
                end
            end
            S_MAP_RE:
            begin
                if (mul_rsp.done)
                begin
                    cre_next          = met_pkg::sat_add(cfg.center_re, mul_result);
                    mul_req.start     = 1'b1;
                    mul_req.shift_sel = met_pkg::SHIFT_MAP;
                    mul_a             = {{(CB-OB){d_im_reg[OB-1]}}, d_im_reg};
                    mul_b             = step_s;
                    state_next        = S_MAP_IM;
                end
            end
            S_MAP_IM:
            begin
                if (mul_rsp.done)
                begin
                    cim_next   = met_pkg::sat_add(cfg.center_im, mul_result);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (it_reg >= cfg.max_iterations)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_a         = zr_reg;
                    mul_b         = zr_reg;
                    state_next    = S_SQ_RE;
                end
            end
            S_SQ_RE:
            begin
                if (mul_rsp.done)
                begin
                    r2_next       = mul_result;
                    mul_req.start = 1'b1;
                    mul_a         = zi_reg;
                    mul_b         = zi_reg;
                    state_next    = S_SQ_IM;
                end
            end
            S_SQ_IM:
            begin
                if (mul_rsp.done)
                begin
                    if (esc_sum >= $signed({1'b0, cfg.bailout_squared}))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // r2 now holds re^2 - im^2
                        r2_next           = met_pkg::sat_sub(r2_reg, mul_result);
                        mul_req.start     = 1'b1;
                        mul_req.shift_sel = met_pkg::SHIFT_DOUBLE;
                        mul_a             = zr_reg;
                        mul_b             = zi_reg;
                        state_next        = S_CROSS;
                    end
                end
            end
            S_CROSS:
            begin
                if (mul_rsp.done)
                begin
                    zr_next    = met_pkg::sat_add(r2_reg, cre_reg);
                    zi_next    = met_pkg::sat_add(mul_result, cim_reg);
                    it_next    = it_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.iteration_count = it_reg;
                    out_item_next.interior        = (it_reg == cfg.max_iterations);
                    out_item_next.final_re        = zr_reg;
                    out_item_next.final_im        = zi_reg;
                    out_item_next.pixel_index     = index_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        index_reg    <= index_next;
        d_im_reg     <= d_im_next;
        cre_reg      <= cre_next;
        cim_reg      <= cim_next;
        zr_reg       <= zr_next;
        zi_reg       <= zi_next;
        r2_reg       <= r2_next;
        it_reg       <= it_next;
    end

endmodule

[tb/tb.sv]
module tb;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam int CB = met_pkg::COORD_BITS;
    localparam int SB = met_pkg::STEP_BITS;
    localparam int ZB = met_pkg::SIZE_BITS;
    localparam int NB = met_pkg::COUNT_BITS;
    localparam int DB = met_pkg::DIM_BITS;
    localparam int IB = met_pkg::INDEX_BITS;
    localparam int FB = met_pkg::FRAC_BITS;
    localparam int XB = met_pkg::CFG_INDEX_BITS;
    localparam int WB = met_pkg::CFG_DATA_BITS;

    localparam longint COORD_TOP   = 64'sd140737488355327;
    localparam longint COORD_BOT   = -COORD_TOP - 1;
    localparam int     STUCK_LIMIT = 30000;
    localparam int     TAIL_CYCLES = 50;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic [XB-1:0]      cfg_index = '0;
    logic [WB-1:0]      cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    met_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    met_pkg::out_item_t out_item;

    met_pkg::cfg_t      view = met_pkg::CFG_RESET;   // register contents as the block should hold them
    met_pkg::out_item_t escape_q[$];                  // predicted results, oldest first
    met_pkg::out_item_t oldest;
    int                 mismatches    = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 hold_off_len  = 0;
    int                 stuck_cycles  = 0;

    mandelbrot_escape_time_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- escape-time predictor ----------------

    function automatic longint clamp_coord(input logic signed [127:0] s);
        if (s > COORD_TOP)
            return COORD_TOP;
        if (s < COORD_BOT)
            return COORD_BOT;
        return s[63:0];
    endfunction

    function automatic longint coord_add(input longint a, input longint b);
        return clamp_coord(a + b);
    endfunction

    // floor(a*b / 2^sh), saturated
    function automatic longint fx_product(input longint a, input longint b, input int sh);
        logic signed [127:0] p;
        p = a;
        p = p * b;
        p = p >>> sh;
        return clamp_coord(p);
    endfunction

    // offset is (2*pixel - size) * step / 2, so odd sizes keep the half-pixel center
    function automatic longint pixel_to_plane(input longint centre, input longint pix,
                                              input longint size, input longint step);
        longint d;
        d = 2 * pix - size;
        return coord_add(centre, fx_product(d, step, 1));
    endfunction

    function automatic met_pkg::out_item_t escape_time(input met_pkg::cfg_t v,
                                                       input met_pkg::in_item_t px);
        met_pkg::out_item_t r;
        longint             cre, cim, zr, zi, r2, i2, nr, bail, idx;
        int unsigned        it;
        cre  = pixel_to_plane(v.center_re, px.column, v.image_width, v.pixel_step);
        cim  = pixel_to_plane(v.center_im, px.row, v.image_height, v.pixel_step);
        bail = v.bailout_squared;
        zr   = 0;
        zi   = 0;
        it   = 0;
        while (it < v.max_iterations)
        begin
            r2 = fx_product(zr, zr, FB);
            i2 = fx_product(zi, zi, FB);
            if (coord_add(r2, i2) >= bail)
                break;
            nr = coord_add(coord_add(r2, -i2), cre);
            zi = coord_add(fx_product(zr, zi, FB - 1), cim);
            zr = nr;
            it++;
        end
        idx = longint'(px.row) * longint'(v.image_width) + longint'(px.column);
        r.iteration_count = it[NB-1:0];
        r.interior        = (it == v.max_iterations);
        r.final_re        = zr[CB-1:0];
        r.final_im        = zi[CB-1:0];
        r.pixel_index     = idx[IB-1:0];
        return r;
    endfunction

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (escape_q.size() == 0)
            begin
                $display("%0t: result with no pixel pending, expected none, got %p",
                         $time, out_item);
                mismatches++;
            end
            else
            begin
                oldest = escape_q.pop_front();
                check_field("iteration_count", oldest.iteration_count, out_item.iteration_count);
                check_field("interior", oldest.interior, out_item.interior);
                check_field("final_re", oldest.final_re, out_item.final_re);
                check_field("final_im", oldest.final_im, out_item.final_im);
                check_field("pixel_index", oldest.pixel_index, out_item.pixel_index);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // watchdog: too long without any item moving on either channel
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------- stimulus helpers ----------------

    function automatic met_pkg::in_item_t pixel(input int col, input int row);
        met_pkg::in_item_t px;
        px.column = col[DB-1:0];
        px.row    = row[DB-1:0];
        return px;
    endfunction

    // mostly inside the image, sometimes anywhere in the 12-bit range
    function automatic met_pkg::in_item_t random_pixel();
        met_pkg::in_item_t px;
        int                w, h;
        w = (view.image_width > 4096) ? 4096 : view.image_width;
        h = (view.image_height > 4096) ? 4096 : view.image_height;
        if (w == 0 || $urandom_range(0, 9) == 0)
            px.column = DB'($urandom);
        else
            px.column = DB'($urandom_range(0, w - 1));
        if (h == 0 || $urandom_range(0, 9) == 0)
            px.row = DB'($urandom);
        else
            px.row = DB'($urandom_range(0, h - 1));
        return px;
    endfunction

    function automatic met_pkg::cfg_t random_view(input bit noise);
        met_pkg::cfg_t v;
        longint        w;
        if (noise)
        begin
            v.center_re       = CB'({$urandom, $urandom});
            v.center_im       = CB'({$urandom, $urandom});
            v.pixel_step      = SB'({$urandom, $urandom});
            v.image_width     = ZB'($urandom);
            v.image_height    = ZB'($urandom);
            v.max_iterations  = NB'($urandom_range(0, 24));
            v.bailout_squared = SB'({$urandom, $urandom});
        end
        else
        begin
            // framed around the set: center re in [-2, 0.5], center im in [-1, 1]
            v.image_width  = ($urandom_range(0, 7) == 0) ? ZB'($urandom_range(0, 8191))
                                                         : ZB'($urandom_range(1, 4096));
            v.image_height = ($urandom_range(0, 7) == 0) ? ZB'($urandom_range(0, 8191))
                                                         : ZB'($urandom_range(1, 4096));
            w = v.image_width;
            if (w == 0)
                w = 1;
            v.pixel_step = SB'((805306368 / w) * $urandom_range(1, 4) / 2);
            v.center_re  = CB'(-(64'sd1 <<< 29) + longint'($urandom_range(0, 671088640)));
            v.center_im  = CB'(longint'($urandom_range(0, 1 << 29)) - (64'sd1 <<< 28));
            v.max_iterations = ($urandom_range(0, 15) == 0) ? NB'($urandom_range(0, 2))
                                                            : NB'($urandom_range(1, 24));
            case ($urandom_range(0, 3))
                0: v.bailout_squared = 47'd1073741824;     // 4.0
                1: v.bailout_squared = met_pkg::CFG_RESET.bailout_squared;
                2: v.bailout_squared = SB'($urandom_range(0, 32'hFFFF_FFFF));
                default: v.bailout_squared = SB'({$urandom, $urandom});
            endcase
        end
        return v;
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SEND:
            begin
                send_idle_pct = 50;
                stall_pct     = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct = 0;
                stall_pct     = 50;
            end
            default:
            begin
                send_idle_pct = 10;
                stall_pct     = 10;
            end
        endcase
    endtask

    task automatic send_pixel(input met_pkg::in_item_t px);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        escape_q.insert(escape_q.size(), escape_time(view, px));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (escape_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [XB-1:0] idx, input logic [WB-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // unused upper data bits carry junk; the block must ignore them
    task automatic load_view(input met_pkg::cfg_t v);
        logic [WB-1:0] junk;
        junk = WB'({$urandom, $urandom});
        wait_drained();
        write_cfg(met_pkg::REG_CENTER_RE, v.center_re);
        write_cfg(met_pkg::REG_CENTER_IM, v.center_im);
        write_cfg(met_pkg::REG_PIXEL_STEP, {junk[WB-1], v.pixel_step});
        write_cfg(met_pkg::REG_IMAGE_WIDTH, {junk[WB-1:ZB], v.image_width});
        write_cfg(met_pkg::REG_IMAGE_HEIGHT, {junk[WB-1:ZB], v.image_height});
        write_cfg(met_pkg::REG_MAX_ITERATIONS, {junk[WB-1:NB], v.max_iterations});
        write_cfg(met_pkg::REG_BAILOUT, {junk[WB-1], v.bailout_squared});
        cfg_write <= 1'b0;
        view = v;
    endtask

    // ---------------- tests ----------------

    // registers as left by reset; the image center is interior at the full limit
    task automatic test_reset_view();
        set_idling(IDLE_NONE);
        send_pixel(pixel(512, 384));
        send_pixel(pixel(0, 0));
        send_pixel(pixel(1023, 767));
        send_pixel(pixel(4095, 4095));
    endtask

    task automatic test_view_extremes();
        met_pkg::cfg_t v;
        // far corner with zero step: escapes after one update even at the top limit
        v.center_re       = met_pkg::COORD_MAX;
        v.center_im       = met_pkg::COORD_MAX;
        v.pixel_step      = '0;
        v.image_width     = 13'd8191;
        v.image_height    = 13'd0;
        v.max_iterations  = 16'hFFFF;
        v.bailout_squared = '1;
        load_view(v);
        send_pixel(pixel(0, 0));
        send_pixel(pixel(4095, 4095));     // index wraps
        send_pixel(pixel(4095, 0));
        // zero bailout with saturating mapping
        v.center_re       = met_pkg::COORD_MIN;
        v.center_im       = met_pkg::COORD_MIN;
        v.pixel_step      = '1;
        v.image_width     = 13'd0;
        v.image_height    = 13'd4096;
        v.max_iterations  = 16'd1;
        v.bailout_squared = '0;
        load_view(v);
        send_pixel(pixel(0, 4095));
        send_pixel(pixel(2048, 0));
        // huge step on a one-pixel image: mapping and squares saturate
        v.center_re       = '0;
        v.center_im       = '0;
        v.pixel_step      = '1;
        v.image_width     = 13'd1;
        v.image_height    = 13'd1;
        v.max_iterations  = 16'd3;
        v.bailout_squared = '1;
        load_view(v);
        send_pixel(pixel(0, 0));
        send_pixel(pixel(4095, 1));
        send_pixel(pixel(1, 0));
    endtask

    task automatic test_zero_limits();
        met_pkg::cfg_t v;
        v = met_pkg::CFG_RESET;
        v.center_re      = -48'sd134217728;   // -0.5
        v.image_width    = 13'd640;
        v.image_height   = 13'd480;
        v.max_iterations = 16'd0;
        load_view(v);
        send_pixel(pixel(320, 240));
        send_pixel(pixel(0, 479));
        v.bailout_squared = '0;
        load_view(v);
        send_pixel(pixel(1, 1));
    endtask

    // receiver holds off while pixels keep coming, then the sender waits for all results
    task automatic test_backpressure();
        met_pkg::cfg_t v;
        v.center_re       = -48'sd201326592;  // -0.75
        v.center_im       = '0;
        v.pixel_step      = 47'd12582912;     // 3/64
        v.image_width     = 13'd64;
        v.image_height    = 13'd48;
        v.max_iterations  = 16'd8;
        v.bailout_squared = 47'd1073741824;
        load_view(v);
        set_idling(IDLE_NONE);
        hold_off_len = 600;
        for (int n = 0; n < 12; n++)
            send_pixel(random_pixel());
        wait_drained();
        for (int n = 0; n < 12; n++)
            send_pixel(random_pixel());
    endtask

    task automatic test_random_views();
        for (int phase = 0; phase < 16; phase++)
        begin
            load_view(random_view($urandom_range(0, 3) == 0));
            set_idling(idle_mode_t'(phase % 4));
            for (int n = 0; n < 100; n++)
                send_pixel(random_pixel());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_view();
        test_view_extremes();
        test_zero_limits();
        test_backpressure();
        test_random_views();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && escape_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/met_pkg.sv
hw/rtl/met_fifo.sv
hw/rtl/met_front.sv
hw/rtl/met_mul.sv
hw/rtl/met_back.sv
hw/rtl/mandelbrot_escape_time_core.sv
tb/tb.sv
